// ----- rtl/core/sptab_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sptab_pkg;

    localparam int unsigned COEF_W          = 16;
    localparam int unsigned EXPO_W          = 10;
    localparam int unsigned SUM_W           = COEF_W + 1;
    localparam int unsigned DEF_TABLE_TERMS = 16;

    typedef enum logic [1:0] {
        OP_INS_A = 2'd0,
        OP_INS_B = 2'd1,
        OP_ADD   = 2'd2,
        OP_CLR   = 2'd3
    } op_t;

    // One stored term: coefficient bits (two's complement) and exponent.
    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic [EXPO_W-1:0] expo;
    } term_t;

    // Request from the sequencer to the result stage.
    typedef struct packed {
        logic              push;
        logic              flush;
        logic [SUM_W-1:0]  coef;
        logic [EXPO_W-1:0] expo;
    } emit_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/sparse_poly_table_add_unit.sv -----
// Two sorted term tables (A and B) with a merging adder. Issue a command by
// raising start while busy is low; the beat is taken on that edge. Inserts
// and clears produce nothing; an add produces a run of sum terms, at most
// one beat per merge step, marked by sum_valid, in descending exponent order,
// with last on the final beat. The receiver cannot stall: each result beat is
// shown for a single cycle and must be captured then. A clear, or an insert
// with a zero coefficient, completes in the accepting cycle without raising
// busy. An insert walks its table through a synchronous memory with one read
// and one write port, visiting each entry through S_INS_RD, which issues
// the read, then S_INS_EV, which compares and writes back; it stops at an
// existing exponent and replaces its coefficient, or places the new term and
// pushes the rest down, dropping the lowest term when the table is full. An
// add reads A and B together in S_ADD_RD and merges them in S_ADD_EV for each
// step; the last beat is shown in the first cycle in which busy is low again.
// Both tables come out of reset empty with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sparse_poly_table_add_unit
    import sptab_pkg::*;
#(
    parameter int unsigned TABLE_TERMS = DEF_TABLE_TERMS
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic        [1:0]        operation,
    input  wire logic signed [COEF_W-1:0] coefficient,
    input  wire logic        [EXPO_W-1:0] exponent,
    output logic                          sum_valid,
    output logic signed [SUM_W-1:0]       sum_coef,
    output logic        [EXPO_W-1:0]      sum_expo,
    output logic                          last
);

    // Address width of a table, and a count width that can hold a full table.
    localparam int unsigned ADDR_W = (TABLE_TERMS > 1) ? $clog2(TABLE_TERMS) : 1;
    localparam int unsigned CNT_W  = $clog2(TABLE_TERMS + 1);

    logic              a_we, b_we;
    logic [ADDR_W-1:0] wr_addr;
    term_t             wr_data;
    logic              a_re, b_re;
    logic [ADDR_W-1:0] a_raddr, b_raddr;
    term_t             a_rdata, b_rdata;
    emit_req_t         emit;

    // Sequencer: decode commands, walk the tables, read-modify-write them.
    sptab_seq #(
        .TERMS  (TABLE_TERMS),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .coefficient (coefficient),
        .exponent    (exponent),
        .a_we        (a_we),
        .b_we        (b_we),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .a_re        (a_re),
        .a_raddr     (a_raddr),
        .a_rdata     (a_rdata),
        .b_re        (b_re),
        .b_raddr     (b_raddr),
        .b_rdata     (b_rdata),
        .emit        (emit)
    );

    // Table A storage.
    sptab_mem #(
        .DEPTH  (TABLE_TERMS),
        .ADDR_W (ADDR_W)
    ) u_mem_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (a_re),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    // Table B storage.
    sptab_mem #(
        .DEPTH  (TABLE_TERMS),
        .ADDR_W (ADDR_W)
    ) u_mem_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (b_re),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // Result stage: hold one term back to place the last flag, then drive
    // the registered result ports.
    sptab_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (emit),
        .sum_valid (sum_valid),
        .sum_coef  (sum_coef),
        .sum_expo  (sum_expo),
        .last      (last)
    );

endmodule

`default_nettype wire

// ----- rtl/core/sptab_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sptab_mem
    import sptab_pkg::*;
#(
    parameter int unsigned DEPTH  = DEF_TABLE_TERMS,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire term_t             wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output term_t                  rdata
);

    term_t mem_reg [DEPTH];
    term_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read; hold the last word when not enabled.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sptab_emit.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sptab_emit
    import sptab_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire emit_req_t                req,
    output logic                          sum_valid,
    output logic signed [SUM_W-1:0]       sum_coef,
    output logic        [EXPO_W-1:0]      sum_expo,
    output logic                          last
);

    logic              pend_valid_reg, pend_valid_next;
    logic [SUM_W-1:0]  pend_coef_reg, pend_coef_next;
    logic [EXPO_W-1:0] pend_expo_reg, pend_expo_next;
    logic              valid_reg, valid_next;
    logic [SUM_W-1:0]  coef_reg, coef_next;
    logic [EXPO_W-1:0] expo_reg, expo_next;
    logic              last_reg, last_next;

    // Hold one term back so that the final one can carry the last flag.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_coef_next  = pend_coef_reg;
        pend_expo_next  = pend_expo_reg;
        valid_next      = 1'b0;
        coef_next       = coef_reg;
        expo_next       = expo_reg;
        last_next       = 1'b0;
        if (req.push)
        begin
            valid_next      = pend_valid_reg;
            coef_next       = pend_coef_reg;
            expo_next       = pend_expo_reg;
            pend_valid_next = 1'b1;
            pend_coef_next  = req.coef;
            pend_expo_next  = req.expo;
        end
        else if (req.flush)
        begin
            valid_next      = 1'b1;
            last_next       = 1'b1;
            coef_next       = pend_valid_reg ? pend_coef_reg : '0;
            expo_next       = pend_valid_reg ? pend_expo_reg : '0;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            valid_reg      <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            valid_reg      <= valid_next;
            last_reg       <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_coef_reg <= pend_coef_next;
        pend_expo_reg <= pend_expo_next;
        coef_reg      <= coef_next;
        expo_reg      <= expo_next;
    end

    assign sum_valid = valid_reg;
    assign sum_coef  = $signed(coef_reg);
    assign sum_expo  = expo_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sptab_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sptab_seq
    import sptab_pkg::*;
#(
    parameter int unsigned TERMS  = DEF_TABLE_TERMS,
    parameter int unsigned ADDR_W = (TERMS > 1) ? $clog2(TERMS) : 1,
    parameter int unsigned CNT_W  = $clog2(TERMS + 1)
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic        [1:0]       operation,
    input  wire logic signed [COEF_W-1:0] coefficient,
    input  wire logic        [EXPO_W-1:0] exponent,
    output logic                         a_we,
    output logic                         b_we,
    output logic             [ADDR_W-1:0] wr_addr,
    output term_t                        wr_data,
    output logic                         a_re,
    output logic             [ADDR_W-1:0] a_raddr,
    input  wire term_t                   a_rdata,
    output logic                         b_re,
    output logic             [ADDR_W-1:0] b_raddr,
    input  wire term_t                   b_rdata,
    output emit_req_t                    emit
);

    localparam logic [CNT_W-1:0] TERMS_C = CNT_W'(TERMS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_INS_RD = 5'b00010,
        S_INS_EV = 5'b00100,
        S_ADD_RD = 5'b01000,
        S_ADD_EV = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic              sel_b_reg, sel_b_next;
    logic [COEF_W-1:0] new_coef_reg, new_coef_next;
    logic [EXPO_W-1:0] new_expo_reg, new_expo_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    term_t             carry_reg, carry_next;
    logic              carrying_reg, carrying_next;
    logic [CNT_W-1:0]  na_reg, na_next;
    logic [CNT_W-1:0]  nb_reg, nb_next;
    logic [CNT_W-1:0]  ia_reg, ia_next;
    logic [CNT_W-1:0]  ib_reg, ib_next;

    logic              wr_en;
    logic [CNT_W-1:0]  n_sel;
    term_t             rd_sel;
    term_t             new_term;
    logic              a_more, b_more;
    logic              take_a, take_b;
    logic [SUM_W-1:0]  a_ext, b_ext, sum_ab;

    assign n_sel    = sel_b_reg ? nb_reg : na_reg;
    assign rd_sel   = sel_b_reg ? b_rdata : a_rdata;
    assign new_term = '{coef: new_coef_reg, expo: new_expo_reg};
    assign a_more   = (ia_reg < na_reg);
    assign b_more   = (ib_reg < nb_reg);
    assign a_ext    = {a_rdata.coef[COEF_W-1], a_rdata.coef};
    assign b_ext    = {b_rdata.coef[COEF_W-1], b_rdata.coef};
    assign sum_ab   = a_ext + b_ext;
    assign take_a   = !b_more || (a_more && (a_rdata.expo > b_rdata.expo));
    assign take_b   = !a_more || (b_more && (b_rdata.expo > a_rdata.expo));

    always_comb
    begin
        state_next    = state_reg;
        sel_b_next    = sel_b_reg;
        new_coef_next = new_coef_reg;
        new_expo_next = new_expo_reg;
        k_next        = k_reg;
        carry_next    = carry_reg;
        carrying_next = carrying_reg;
        na_next       = na_reg;
        nb_next       = nb_reg;
        ia_next       = ia_reg;
        ib_next       = ib_reg;
        wr_en         = 1'b0;
        wr_addr       = k_reg[ADDR_W-1:0];
        wr_data       = new_term;
        a_re          = 1'b0;
        b_re          = 1'b0;
        a_raddr       = ia_reg[ADDR_W-1:0];
        b_raddr       = ib_reg[ADDR_W-1:0];
        emit          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (op_t'(operation))
                        OP_INS_A, OP_INS_B:
                        begin
                            // Drop a zero coefficient at once.
                            if (coefficient != '0)
                            begin
                                sel_b_next    = (op_t'(operation) == OP_INS_B);
                                new_coef_next = coefficient;
                                new_expo_next = exponent;
                                k_next        = '0;
                                carrying_next = 1'b0;
                                state_next    = S_INS_RD;
                            end
                        end
                        OP_ADD:
                        begin
                            ia_next    = '0;
                            ib_next    = '0;
                            state_next = S_ADD_RD;
                        end
                        OP_CLR:
                        begin
                            na_next = '0;
                            nb_next = '0;
                        end
                    endcase
                end
            end

            S_INS_RD:
            begin
                if (k_reg < n_sel)
                begin
                    a_re       = !sel_b_reg;
                    b_re       = sel_b_reg;
                    a_raddr    = k_reg[ADDR_W-1:0];
                    b_raddr    = k_reg[ADDR_W-1:0];
                    state_next = S_INS_EV;
                end
                else
                begin
                    // End of the valid entries: append unless full.
                    if (n_sel < TERMS_C)
                    begin
                        wr_en   = 1'b1;
                        wr_data = carrying_reg ? carry_reg : new_term;
                        if (sel_b_reg)
                        begin
                            nb_next = nb_reg + 1'b1;
                        end
                        else
                        begin
                            na_next = na_reg + 1'b1;
                        end
                    end
                    state_next = S_IDLE;
                end
            end

            S_INS_EV:
            begin
                priority if (carrying_reg)
                begin
                    wr_en      = 1'b1;
                    wr_data    = carry_reg;
                    carry_next = rd_sel;
                    k_next     = k_reg + 1'b1;
                    state_next = S_INS_RD;
                end
                else if (rd_sel.expo > new_expo_reg)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_INS_RD;
                end
                else if (rd_sel.expo == new_expo_reg)
                begin
                    wr_en      = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    wr_en         = 1'b1;
                    carry_next    = rd_sel;
                    carrying_next = 1'b1;
                    k_next        = k_reg + 1'b1;
                    state_next    = S_INS_RD;
                end
            end

            S_ADD_RD:
            begin
                if (a_more || b_more)
                begin
                    a_re       = a_more;
                    b_re       = b_more;
                    state_next = S_ADD_EV;
                end
                else
                begin
                    emit.flush = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_ADD_EV:
            begin
                priority if (take_a)
                begin
                    emit.push = 1'b1;
                    emit.coef = a_ext;
                    emit.expo = a_rdata.expo;
                    ia_next   = ia_reg + 1'b1;
                end
                else if (take_b)
                begin
                    emit.push = 1'b1;
                    emit.coef = b_ext;
                    emit.expo = b_rdata.expo;
                    ib_next   = ib_reg + 1'b1;
                end
                else
                begin
                    emit.push = (sum_ab != '0);
                    emit.coef = sum_ab;
                    emit.expo = a_rdata.expo;
                    ia_next   = ia_reg + 1'b1;
                    ib_next   = ib_reg + 1'b1;
                end
                state_next = S_ADD_RD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign a_we = wr_en && !sel_b_reg;
    assign b_we = wr_en && sel_b_reg;
    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            carrying_reg <= 1'b0;
            na_reg       <= '0;
            nb_reg       <= '0;
            k_reg        <= '0;
            ia_reg       <= '0;
            ib_reg       <= '0;
            sel_b_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            carrying_reg <= carrying_next;
            na_reg       <= na_next;
            nb_reg       <= nb_next;
            k_reg        <= k_next;
            ia_reg       <= ia_next;
            ib_reg       <= ib_next;
            sel_b_reg    <= sel_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_coef_reg <= new_coef_next;
        new_expo_reg <= new_expo_next;
        carry_reg    <= carry_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/sptab_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sptab_checker
    import sptab_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     start,
    input wire logic                     busy,
    input wire logic        [1:0]        operation,
    input wire logic                     sum_valid,
    input wire logic signed [SUM_W-1:0]  sum_coef,
    input wire logic        [EXPO_W-1:0] sum_expo,
    input wire logic                     last
);

    // A run that has not ended keeps the block busy.
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_valid && !last) |-> busy)
        else $error("result beat without last while block idle");

    // Result beats only follow busy cycles.
    a_beat_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid |-> $past(busy))
        else $error("result beat not preceded by busy");

    // An add always starts a walk.
    a_add_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_ADD)) |=> busy)
        else $error("add command did not raise busy");

    // A clear completes in the accepting cycle.
    a_clr_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_CLR)) |=> !busy)
        else $error("clear command raised busy");

    // A zero coefficient only appears as the lone empty-sum term.
    a_zero_term: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_valid && (sum_coef == '0)) |-> (last && (sum_expo == '0)))
        else $error("zero sum term emitted inside a run");

endmodule

bind sparse_poly_table_add_unit sptab_checker u_sptab_checker (.*);

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import sptab_pkg::*;

    localparam int TERMS          = DEF_TABLE_TERMS;
    localparam int TAB_A          = 0;
    localparam int TAB_B          = 1;
    localparam int RANDOM_ITEMS   = 260;
    // Give an add of two full tables, the longest sender gap and the tail
    // hold-off plenty of room.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 4 * TERMS + 16;

    // One expected sum beat.
    typedef struct {
        logic signed [SUM_W-1:0] coef;
        logic [EXPO_W-1:0]       expo;
        logic                    last;
    } sum_term_t;

    // Keeps its own copy of both term tables and the queue of sum beats that
    // the accepted adds still owe.
    class sum_run_tracker;
        logic signed [COEF_W-1:0] coef_tab[2][TERMS];
        logic [EXPO_W-1:0]        expo_tab[2][TERMS];
        int                       len_tab[2];
        sum_term_t                due_terms[$];
        int                       errors;

        function new();
            len_tab[TAB_A] = 0;
            len_tab[TAB_B] = 0;
            errors = 0;
        endfunction

        function int pending();
            return due_terms.size();
        endfunction

        function void place_term(int t, logic signed [COEF_W-1:0] c, logic [EXPO_W-1:0] e);
            int pos = 0;
            int k;
            if (c == 0)
                return;
            while (pos < len_tab[t] && expo_tab[t][pos] > e)
                pos++;
            if (pos < len_tab[t] && expo_tab[t][pos] == e)
            begin
                coef_tab[t][pos] = c;
                return;
            end
            // full table and the new term sits below every entry
            if (pos >= TERMS)
                return;
            k = (len_tab[t] < TERMS) ? len_tab[t] : TERMS - 1;
            while (k > pos)
            begin
                coef_tab[t][k] = coef_tab[t][k - 1];
                expo_tab[t][k] = expo_tab[t][k - 1];
                k--;
            end
            coef_tab[t][pos] = c;
            expo_tab[t][pos] = e;
            if (len_tab[t] < TERMS)
                len_tab[t]++;
        endfunction

        function void merge_tables();
            logic signed [SUM_W-1:0] run_coef[2 * TERMS];
            logic [EXPO_W-1:0]       run_expo[2 * TERMS];
            logic signed [SUM_W-1:0] s;
            sum_term_t               beat;
            int                      ia = 0;
            int                      ib = 0;
            int                      n = 0;
            int                      na;
            int                      nb;
            na = len_tab[TAB_A];
            nb = len_tab[TAB_B];
            while (ia < na || ib < nb)
            begin
                if (ib >= nb || (ia < na && expo_tab[TAB_A][ia] > expo_tab[TAB_B][ib]))
                begin
                    run_coef[n] = coef_tab[TAB_A][ia];
                    run_expo[n] = expo_tab[TAB_A][ia];
                    n++;
                    ia++;
                end
                else if (ia >= na || expo_tab[TAB_B][ib] > expo_tab[TAB_A][ia])
                begin
                    run_coef[n] = coef_tab[TAB_B][ib];
                    run_expo[n] = expo_tab[TAB_B][ib];
                    n++;
                    ib++;
                end
                else
                begin
                    s = coef_tab[TAB_A][ia] + coef_tab[TAB_B][ib];
                    if (s != 0)
                    begin
                        run_coef[n] = s;
                        run_expo[n] = expo_tab[TAB_A][ia];
                        n++;
                    end
                    ia++;
                    ib++;
                end
            end
            if (n == 0)
            begin
                run_coef[0] = '0;
                run_expo[0] = '0;
                n = 1;
            end
            for (int i = 0; i < n; i++)
            begin
                beat.coef = run_coef[i];
                beat.expo = run_expo[i];
                beat.last = (i == n - 1);
                due_terms.push_back(beat);
            end
        endfunction

        function void note_beat(op_t op, logic signed [COEF_W-1:0] c, logic [EXPO_W-1:0] e);
            case (op)
                OP_INS_A: place_term(TAB_A, c, e);
                OP_INS_B: place_term(TAB_B, c, e);
                OP_ADD:   merge_tables();
                default:
                begin
                    len_tab[TAB_A] = 0;
                    len_tab[TAB_B] = 0;
                end
            endcase
        endfunction

        function void check_beat(logic signed [SUM_W-1:0] c, logic [EXPO_W-1:0] e, logic l);
            sum_term_t want;
            if (due_terms.size() == 0)
            begin
                $error("sum beat with nothing owed: sum_coef %0d sum_expo %0d last %0b",
                       c, e, l);
                errors++;
                return;
            end
            want = due_terms.pop_front();
            if (c !== want.coef)
            begin
                $error("sum_coef expected %0d actual %0d", want.coef, c);
                errors++;
            end
            if (e !== want.expo)
            begin
                $error("sum_expo expected %0d actual %0d", want.expo, e);
                errors++;
            end
            if (l !== want.last)
            begin
                $error("last expected %0b actual %0b", want.last, l);
                errors++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [1:0]               operation = '0;
    logic signed [COEF_W-1:0] coefficient = '0;
    logic [EXPO_W-1:0]        exponent = '0;
    logic                     busy;
    logic                     sum_valid;
    logic signed [SUM_W-1:0]  sum_coef;
    logic [EXPO_W-1:0]        sum_expo;
    logic                     last;

    sum_run_tracker tracker = new();
    int             items_sent = 0;
    int             burst_left = 0;
    int             quiet_cycles = 0;

    sparse_poly_table_add_unit #(
        .TABLE_TERMS (TERMS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .coefficient (coefficient),
        .exponent    (exponent),
        .sum_valid   (sum_valid),
        .sum_coef    (sum_coef),
        .sum_expo    (sum_expo),
        .last        (last)
    );

    always #10 clk = ~clk;

    // The receiver cannot hold results off: capture every strobed beat.
    always @(posedge clk)
    begin
        if (rst_n && sum_valid)
            tracker.check_beat(sum_coef, sum_expo, last);
    end

    // Count cycles in which no beat moves either way; a hung block ends here.
    always @(posedge clk)
    begin
        if ((start && !busy) || sum_valid)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Coefficients: zero now and then, the extremes now and then, else any value.
    function automatic logic signed [COEF_W-1:0] rand_coef();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        return COEF_W'($urandom());
    endfunction

    // Any exponent across the full field.
    function automatic logic [EXPO_W-1:0] rand_expo();
        return EXPO_W'($urandom());
    endfunction

    // Present one command beat and hold it until the block takes it. Then
    // either keep start high for the next beat of the burst, or drop it for
    // a random gap and draw a new burst length.
    task automatic send_beat(input op_t op, input logic signed [COEF_W-1:0] c,
                             input logic [EXPO_W-1:0] e);
        int gap;
        start       <= 1'b1;
        operation   <= op;
        coefficient <= c;
        exponent    <= e;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.note_beat(op, c, e);
        // inserts with a zero coefficient are ignored and do not count
        if (op == OP_ADD || op == OP_CLR || c != 0)
            items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 8);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Drop start and hold off until every owed sum beat has arrived.
    task automatic drain_sums();
        start <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int                       kind;
        int                       n;
        int                       side;
        int                       base;
        int                       narrow;
        logic signed [COEF_W-1:0] c;
        logic [EXPO_W-1:0]        e;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty sum, field extremes, ignored zero, cancellation,
        // replacement, clear, one-sided sum.
        send_beat(OP_ADD, rand_coef(), rand_expo());
        send_beat(OP_INS_A, 16'sh7FFF, 10'd1023);
        send_beat(OP_INS_A, 16'sh8000, 10'd0);
        send_beat(OP_INS_B, 16'sh7FFF, 10'd1023);
        send_beat(OP_INS_B, 16'sh8000, 10'd0);
        send_beat(OP_INS_A, 16'sh0000, 10'd77);
        send_beat(OP_INS_A, 16'sd12345, 10'b1010101010);
        send_beat(OP_INS_B, -16'sd12345, 10'b1010101010);
        send_beat(OP_INS_B, 16'sd1, 10'b0101010101);
        send_beat(OP_ADD, rand_coef(), rand_expo());
        send_beat(OP_INS_A, -16'sd1, 10'd1023);
        send_beat(OP_ADD, rand_coef(), rand_expo());
        send_beat(OP_CLR, rand_coef(), rand_expo());
        send_beat(OP_ADD, rand_coef(), rand_expo());
        send_beat(OP_INS_B, 16'sd7, 10'd5);
        send_beat(OP_ADD, rand_coef(), rand_expo());
        drain_sums();

        // Random: mostly well-formed polynomial pairs followed by an add,
        // with full-table fills, noise and back-to-back adds mixed in. The
        // first sequence is always a fill so the full-table paths are hit.
        kind = 6;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            case (kind)
                6:
                begin
                    // fill one table past capacity, then probe below all and
                    // in the middle of the full table
                    send_beat(OP_CLR, rand_coef(), rand_expo());
                    side = $urandom_range(0, 1);
                    n = $urandom_range(TERMS, TERMS + 6);
                    for (int i = 0; i < n; i++)
                    begin
                        c = rand_coef();
                        if (c == 0)
                            c = 16'sd1;
                        send_beat(side ? OP_INS_B : OP_INS_A, c,
                                  EXPO_W'($urandom_range(1, 1023)));
                    end
                    send_beat(side ? OP_INS_B : OP_INS_A, 16'sd3, 10'd0);
                    send_beat(side ? OP_INS_B : OP_INS_A, rand_coef(),
                              EXPO_W'($urandom_range(1, 1023)));
                    for (int i = 0; i < $urandom_range(0, 5); i++)
                        send_beat(side ? OP_INS_A : OP_INS_B, rand_coef(), rand_expo());
                    send_beat(OP_ADD, rand_coef(), rand_expo());
                end
                7:
                begin
                    n = $urandom_range(3, 10);
                    for (int i = 0; i < n; i++)
                        send_beat(op_t'($urandom_range(0, 3)), COEF_W'($urandom()),
                                  rand_expo());
                end
                8:
                begin
                    drain_sums();
                    send_beat(OP_ADD, rand_coef(), rand_expo());
                    send_beat(OP_ADD, rand_coef(), rand_expo());
                end
                9:
                begin
                    send_beat(OP_CLR, rand_coef(), rand_expo());
                    send_beat(OP_ADD, rand_coef(), rand_expo());
                end
                default:
                begin
                    if ($urandom_range(0, 2) == 0)
                        send_beat(OP_CLR, rand_coef(), rand_expo());
                    // a narrow exponent window forces replacements and
                    // matching terms across the two tables
                    narrow = $urandom_range(0, 1);
                    base = $urandom_range(0, 1023 - 31);
                    n = $urandom_range(1, 12);
                    for (int i = 0; i < n; i++)
                    begin
                        e = narrow ? EXPO_W'(base + $urandom_range(0, 31)) : rand_expo();
                        c = rand_coef();
                        side = $urandom_range(0, 1);
                        send_beat(side ? OP_INS_B : OP_INS_A, c, e);
                        if ($urandom_range(0, 3) == 0)
                            send_beat(side ? OP_INS_A : OP_INS_B, -c, e);
                    end
                    send_beat(OP_ADD, rand_coef(), rand_expo());
                end
            endcase
            kind = $urandom_range(0, 9);
        end

        drain_sums();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
